// File: src/tre_pkg.sv
package tre_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned REG_IDX_W = 5;
    localparam int unsigned FUNC_W    = 3;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned COUNT_W   = 6;

    typedef logic [FUNC_W-1:0]           func_t;
    typedef logic [REG_IDX_W-1:0]        reg_idx_t;
    typedef logic signed [WORD_W-1:0]    word_t;
    typedef logic [STATUS_W-1:0]         status_t;
    typedef logic [COUNT_W-1:0]          count_t;

    localparam func_t FUNC_ADD = 3'd0;
    localparam func_t FUNC_SUB = 3'd1;
    localparam func_t FUNC_MUL = 3'd2;
    localparam func_t FUNC_DIV = 3'd3;
    localparam func_t FUNC_MOD = 3'd4;
    localparam func_t FUNC_LDI = 3'd5;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_NOT_IN_USE = 2'd1;
    localparam status_t ST_UNKNOWN    = 2'd2;
    localparam status_t ST_DIV_ZERO   = 2'd3;

    localparam count_t REGS_IN_USE_RESET = 6'd32;

endpackage

// File: src/tre_if.sv
interface tre_req_if;
    logic                valid;
    logic                ready;
    tre_pkg::func_t      func;
    tre_pkg::reg_idx_t   dest_index;
    tre_pkg::reg_idx_t   src_a_index;
    tre_pkg::reg_idx_t   src_b_index;
    tre_pkg::word_t      immediate;

    modport source (
        output valid, func, dest_index, src_a_index, src_b_index, immediate,
        input  ready
    );
    modport sink (
        input  valid, func, dest_index, src_a_index, src_b_index, immediate,
        output ready
    );
endinterface

interface tre_rsp_if;
    logic                valid;
    logic                ready;
    tre_pkg::word_t      dest_value;
    tre_pkg::status_t    status;

    modport source (
        output valid, dest_value, status,
        input  ready
    );
    modport sink (
        input  valid, dest_value, status,
        output ready
    );
endinterface

interface tre_cfg_if;
    logic                valid;
    logic                ready;
    tre_pkg::count_t     regs_in_use;

    modport source (
        output valid, regs_in_use,
        input  ready
    );
    modport sink (
        input  valid, regs_in_use,
        output ready
    );
endinterface

// File: src/tre_ram.sv
module tre_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/three_register_alu_execute_unit.sv
// Three-register integer execute unit with a signed 32-bit register file.
// The req channel takes one decoded instruction per transaction (func,
// destination, two sources and an immediate). The rsp channel returns one
// transaction per instruction with the destination's contents after the
// step and a status. The cfg channel writes the count of registers in use;
// it is always ready and should only be written while the unit is idle.
// Add, subtract, load immediate and every instruction that writes nothing
// pass through the read, operate, write, read-back and output states.
// Multiply, divide and remainder run 32 iterations of the shared 33-bit
// adder, one bit per cycle, between operate and write. The unit takes the
// next request only once its last result is in the output register.
// Reset clears the register file through per-entry valid bits, so every
// register reads as zero right away, and sets the count in use to 32.
// Results wait in an output register; a stalled receiver holds the unit
// once it has finished the next instruction, and req.ready stays low until then.
module three_register_alu_execute_unit #(
    parameter int unsigned NUM_REGS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    tre_req_if.sink   req,
    tre_rsp_if.source rsp,
    tre_cfg_if.sink   cfg
);

    import tre_pkg::*;

    localparam int unsigned AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int unsigned CMP_W = 7;
    localparam logic [CMP_W-1:0] NUM_REGS_C = CMP_W'(NUM_REGS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDB   = 3'd1;
    localparam logic [2:0] S_OPS   = 3'd2;
    localparam logic [2:0] S_ITER  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_RDD   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    function automatic logic [AW-1:0] addr_of(input reg_idx_t idx);
        logic [REG_IDX_W+AW-1:0] ext;
        ext = {{AW{1'b0}}, idx};
        return ext[AW-1:0];
    endfunction

    function automatic logic in_range(input reg_idx_t idx);
        return {{(CMP_W-REG_IDX_W){1'b0}}, idx} < NUM_REGS_C;
    endfunction

    logic [2:0]          state_reg, state_next;
    func_t               func_reg, func_next;
    reg_idx_t            dest_reg, dest_next;
    reg_idx_t            srca_reg, srca_next;
    reg_idx_t            srcb_reg, srcb_next;
    logic [WORD_W-1:0]   imm_reg, imm_next;
    logic [WORD_W-1:0]   a_reg, a_next;
    logic [WORD_W-1:0]   result_reg, result_next;
    logic [WORD_W-1:0]   rem_reg, rem_next;
    logic [WORD_W-1:0]   quo_reg, quo_next;
    logic [WORD_W-1:0]   op_reg, op_next;
    logic [4:0]          count_reg, count_next;
    logic                q_neg_reg, q_neg_next;
    logic                r_neg_reg, r_neg_next;
    status_t             status_reg, status_next;
    logic                write_reg, write_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   out_value_reg, out_value_next;
    status_t             out_status_reg, out_status_next;
    count_t              regs_in_use_reg;
    logic [NUM_REGS-1:0] valid_reg;

    logic [AW-1:0]       rd_addr;
    logic [WORD_W-1:0]   rd_data;
    logic [WORD_W-1:0]   rd_val;
    reg_idx_t            rd_idx;
    logic                wr_en;
    logic [WORD_W-1:0]   wr_data;

    logic [WORD_W:0]     add_x;
    logic [WORD_W:0]     add_y;
    logic                add_sub;
    logic [WORD_W+1:0]   add_sum;
    logic                add_ge;
    logic                req_fire;
    logic                not_in_use;

    tre_ram #(
        .WIDTH(WORD_W),
        .DEPTH(NUM_REGS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_of(dest_reg)),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign cfg.ready  = 1'b1;
    assign rsp.valid  = out_valid_reg;
    assign rsp.dest_value = word_t'(out_value_reg);
    assign rsp.status = out_status_reg;

    assign not_in_use = ({1'b0, dest_reg} >= regs_in_use_reg) || !in_range(dest_reg);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = addr_of(req.src_a_index);
            S_RDB:   rd_addr = addr_of(srcb_reg);
            default: rd_addr = addr_of(dest_reg);
        endcase
        case (state_reg)
            S_RDB:   rd_idx = srca_reg;
            S_OPS:   rd_idx = srcb_reg;
            default: rd_idx = dest_reg;
        endcase
        rd_val = (in_range(rd_idx) && valid_reg[addr_of(rd_idx)]) ? rd_data : '0;
    end

    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (state_reg)
            S_OPS:
            begin
                add_x   = {1'b0, a_reg};
                add_y   = {1'b0, rd_val};
                add_sub = (func_reg == FUNC_SUB);
            end
            S_ITER:
            begin
                if (func_reg == FUNC_MUL)
                begin
                    add_x = {1'b0, rem_reg[WORD_W-2:0], 1'b0};
                    add_y = quo_reg[WORD_W-1] ? {1'b0, op_reg} : '0;
                end
                else
                begin
                    add_x   = {rem_reg, quo_reg[WORD_W-1]};
                    add_y   = {1'b0, op_reg};
                    add_sub = 1'b1;
                end
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_x} + (add_sub ? ~{1'b0, add_y} : {1'b0, add_y})
                  + {{(WORD_W+1){1'b0}}, add_sub};
        add_ge  = !add_sum[WORD_W+1];
    end

    always_comb
    begin
        case (func_reg)
            FUNC_MUL: wr_data = rem_reg;
            FUNC_DIV: wr_data = q_neg_reg ? (WORD_W'(0) - quo_reg) : quo_reg;
            FUNC_MOD: wr_data = r_neg_reg ? (WORD_W'(0) - rem_reg) : rem_reg;
            default:  wr_data = result_reg;
        endcase
        wr_en = (state_reg == S_WRITE) && write_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        dest_next       = dest_reg;
        srca_next       = srca_reg;
        srcb_next       = srcb_reg;
        imm_next        = imm_reg;
        a_next          = a_reg;
        result_next     = result_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        q_neg_next      = q_neg_reg;
        r_neg_next      = r_neg_reg;
        status_next     = status_reg;
        write_next      = write_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    func_next  = req.func;
                    dest_next  = req.dest_index;
                    srca_next  = req.src_a_index;
                    srcb_next  = req.src_b_index;
                    imm_next   = WORD_W'(req.immediate);
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                a_next     = rd_val;
                state_next = S_OPS;
            end
            S_OPS:
            begin
                status_next = ST_OK;
                write_next  = 1'b0;
                rem_next    = '0;
                count_next  = '0;
                state_next  = S_WRITE;
                if (not_in_use)
                begin
                    status_next = ST_NOT_IN_USE;
                end
                else
                begin
                    case (func_reg)
                        FUNC_ADD, FUNC_SUB:
                        begin
                            result_next = add_sum[WORD_W-1:0];
                            write_next  = 1'b1;
                        end
                        FUNC_MUL:
                        begin
                            quo_next   = rd_val;
                            op_next    = a_reg;
                            write_next = 1'b1;
                            state_next = S_ITER;
                        end
                        FUNC_DIV, FUNC_MOD:
                        begin
                            if (rd_val == '0)
                            begin
                                status_next = ST_DIV_ZERO;
                            end
                            else
                            begin
                                quo_next   = a_reg[WORD_W-1] ? (WORD_W'(0) - a_reg) : a_reg;
                                op_next    = rd_val[WORD_W-1] ? (WORD_W'(0) - rd_val) : rd_val;
                                q_neg_next = a_reg[WORD_W-1] ^ rd_val[WORD_W-1];
                                r_neg_next = a_reg[WORD_W-1];
                                write_next = 1'b1;
                                state_next = S_ITER;
                            end
                        end
                        FUNC_LDI:
                        begin
                            result_next = imm_reg;
                            write_next  = 1'b1;
                        end
                        default:
                        begin
                            status_next = ST_UNKNOWN;
                        end
                    endcase
                end
            end
            S_ITER:
            begin
                if (func_reg == FUNC_MUL)
                begin
                    rem_next = add_sum[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = add_ge ? add_sum[WORD_W-1:0] : add_x[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], add_ge};
                end
                count_next = count_reg + 5'd1;
                if (count_reg == 5'd31)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_RDD;
            end
            S_RDD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = rd_val;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            regs_in_use_reg <= REGS_IN_USE_RESET;
            valid_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                regs_in_use_reg <= cfg.regs_in_use;
            end
            if (wr_en)
            begin
                valid_reg[addr_of(dest_reg)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        dest_reg       <= dest_next;
        srca_reg       <= srca_next;
        srcb_reg       <= srcb_next;
        imm_reg        <= imm_next;
        a_reg          <= a_next;
        result_reg     <= result_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        op_reg         <= op_next;
        count_reg      <= count_next;
        q_neg_reg      <= q_neg_next;
        r_neg_reg      <= r_neg_next;
        status_reg     <= status_next;
        write_reg      <= write_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

endmodule

// File: src/tre_checker.sv
module tre_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input tre_pkg::word_t   rsp_dest_value,
    input tre_pkg::status_t rsp_status
);

    import tre_pkg::*;

    // Once a request is taken, the request channel stays not ready while the unit is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready ##1 !req_ready ##1 !req_ready)
    else $error("request channel ready again too soon after a transaction");

    // A result is produced only after a request has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared without a preceding instruction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result withdrawn before its transaction completed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> ($stable(rsp_dest_value) && $stable(rsp_status)))
    else $error("stalled result changed");

endmodule

bind three_register_alu_execute_unit tre_checker u_tre_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_dest_value (rsp.dest_value),
    .rsp_status     (rsp.status)
);

// File: tb/tb_three_register_alu_execute_unit.sv
`timescale 1ns / 100ps

module tb_three_register_alu_execute_unit;

    import tre_pkg::*;

    localparam int NUM_REGS        = 32;
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int NUM_PHASES      = 12;

    localparam func_t FUNC_UNKNOWN_LO = FUNC_LDI + 3'd1;
    localparam func_t FUNC_UNKNOWN_HI = '1;

    typedef enum int {
        SEND_STEADY,
        SEND_SHORT_GAPS,
        SEND_LONG_GAPS
    } sender_mode_e;

    typedef enum int {
        RECV_ALWAYS,
        RECV_PATTERN,
        RECV_RANDOM
    } receiver_mode_e;

    typedef struct {
        func_t    func;
        reg_idx_t dest_index;
        reg_idx_t src_a_index;
        reg_idx_t src_b_index;
        word_t    immediate;
    } instr_t;

    typedef struct {
        word_t   dest_value;
        status_t status;
    } alu_result_t;

    logic clk = 1'b0;
    logic rst_n;

    tre_req_if instr_bus ();
    tre_rsp_if result_bus ();
    tre_cfg_if cfg_bus ();

    three_register_alu_execute_unit #(
        .NUM_REGS (NUM_REGS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (instr_bus),
        .rsp   (result_bus),
        .cfg   (cfg_bus)
    );

    instr_t         pending_instrs[$];
    alu_result_t    expected_results[$];
    word_t          shadow_regs[NUM_REGS];
    int             regs_limit;

    int             error_count;
    int             result_count;
    int             status_count[1 << STATUS_W];
    int             cfg_write_count;
    int             watchdog_count;
    bit             instr_fire;
    bit             drain_hold;
    int             burst_left;
    int             gap_left;
    int             sent_total;
    sender_mode_e   sender_mode;
    receiver_mode_e receiver_mode;
    logic [15:0]    ready_pattern;

    always #5 clk = ~clk;

    function automatic bit [WORD_W-1:0] magnitude(bit [WORD_W-1:0] v);
        return v[WORD_W-1] ? ('0 - v) : v;
    endfunction

    function automatic alu_result_t execute_instr(instr_t it);
        alu_result_t       res;
        bit [WORD_W-1:0]   a;
        bit [WORD_W-1:0]   b;
        bit [WORD_W-1:0]   mag;
        bit [WORD_W-1:0]   val;
        bit                write_en;
        a = shadow_regs[it.src_a_index];
        b = shadow_regs[it.src_b_index];
        val = '0;
        write_en = 1'b0;
        res.status = ST_OK;
        if (int'(it.dest_index) >= regs_limit)
        begin
            res.status = ST_NOT_IN_USE;
        end
        else
        begin
            case (it.func)
                FUNC_ADD:
                begin
                    val = a + b;
                    write_en = 1'b1;
                end
                FUNC_SUB:
                begin
                    val = a - b;
                    write_en = 1'b1;
                end
                FUNC_MUL:
                begin
                    val = a * b;
                    write_en = 1'b1;
                end
                FUNC_DIV:
                begin
                    if (b == '0)
                    begin
                        res.status = ST_DIV_ZERO;
                    end
                    else
                    begin
                        mag = magnitude(a) / magnitude(b);
                        val = (a[WORD_W-1] ^ b[WORD_W-1]) ? ('0 - mag) : mag;
                        write_en = 1'b1;
                    end
                end
                FUNC_MOD:
                begin
                    if (b == '0)
                    begin
                        res.status = ST_DIV_ZERO;
                    end
                    else
                    begin
                        mag = magnitude(a) % magnitude(b);
                        val = a[WORD_W-1] ? ('0 - mag) : mag;
                        write_en = 1'b1;
                    end
                end
                FUNC_LDI:
                begin
                    val = it.immediate;
                    write_en = 1'b1;
                end
                default:
                begin
                    res.status = ST_UNKNOWN;
                end
            endcase
            if (write_en)
            begin
                shadow_regs[it.dest_index] = val;
            end
        end
        res.dest_value = shadow_regs[it.dest_index];
        return res;
    endfunction

    function automatic instr_t make_instr(func_t f, reg_idx_t d, reg_idx_t sa, reg_idx_t sb,
                                          word_t imm);
        instr_t it;
        it.func        = f;
        it.dest_index  = d;
        it.src_a_index = sa;
        it.src_b_index = sb;
        it.immediate   = imm;
        return it;
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        int     pick;
        int     span;
        span = (regs_limit > 8) ? 8 : regs_limit;
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            it.func = FUNC_LDI;
        end
        else if (pick < 28)
        begin
            it.func = func_t'($urandom_range(FUNC_UNKNOWN_LO, FUNC_UNKNOWN_HI));
        end
        else
        begin
            it.func = func_t'($urandom_range(FUNC_ADD, FUNC_MOD));
        end
        if (regs_limit == 0 || $urandom_range(0, 9) == 0)
        begin
            it.dest_index = reg_idx_t'($urandom);
        end
        else if ($urandom_range(0, 1) == 1)
        begin
            it.dest_index = reg_idx_t'($urandom_range(0, span - 1));
        end
        else
        begin
            it.dest_index = reg_idx_t'($urandom_range(0, regs_limit - 1));
        end
        it.src_a_index = ($urandom_range(0, 1) == 1) ? reg_idx_t'($urandom_range(0, 7))
                                                      : reg_idx_t'($urandom);
        it.src_b_index = ($urandom_range(0, 1) == 1) ? reg_idx_t'($urandom_range(0, 7))
                                                      : reg_idx_t'($urandom);
        case ($urandom_range(0, 3))
            0: it.immediate = word_t'($urandom);
            1: it.immediate = word_t'(int'($urandom_range(0, 32)) - 16);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: it.immediate = '0;
                    1: it.immediate = {1'b1, {(WORD_W-1){1'b0}}};
                    2: it.immediate = {1'b0, {(WORD_W-1){1'b1}}};
                    default: it.immediate = '1;
                endcase
            end
            default: it.immediate = word_t'($urandom) >>> $urandom_range(0, WORD_W - 2);
        endcase
        return it;
    endfunction

    task automatic write_regs_in_use(count_t value);
        @(negedge clk);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.regs_in_use <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        regs_limit = (int'(value) > NUM_REGS) ? NUM_REGS : int'(value);
        cfg_write_count++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_instrs.size() != 0 || instr_bus.valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        instr_t it;
        if (rst_n && instr_bus.valid && instr_bus.ready)
        begin
            it.func        = instr_bus.func;
            it.dest_index  = instr_bus.dest_index;
            it.src_a_index = instr_bus.src_a_index;
            it.src_b_index = instr_bus.src_b_index;
            it.immediate   = instr_bus.immediate;
            expected_results.push_back(execute_instr(it));
        end
        instr_fire <= rst_n && instr_bus.valid && instr_bus.ready;
    end

    always @(negedge clk)
    begin
        instr_t it;
        if (rst_n && (!instr_bus.valid || instr_fire))
        begin
            if (drain_hold && expected_results.size() == 0)
            begin
                drain_hold = 1'b0;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                instr_bus.valid <= 1'b0;
            end
            else if (drain_hold || pending_instrs.size() == 0)
            begin
                instr_bus.valid <= 1'b0;
            end
            else
            begin
                it = pending_instrs.pop_front();
                instr_bus.valid       <= 1'b1;
                instr_bus.func        <= it.func;
                instr_bus.dest_index  <= it.dest_index;
                instr_bus.src_a_index <= it.src_a_index;
                instr_bus.src_b_index <= it.src_b_index;
                instr_bus.immediate   <= it.immediate;
                sent_total++;
                if (sent_total % 97 == 50)
                begin
                    drain_hold = 1'b1;
                end
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    case (sender_mode)
                        SEND_STEADY:     gap_left = 0;
                        SEND_SHORT_GAPS: gap_left = $urandom_range(0, 8);
                        default:         gap_left = $urandom_range(0, 45);
                    endcase
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            case (receiver_mode)
                RECV_ALWAYS:
                begin
                    result_bus.ready <= 1'b1;
                end
                RECV_PATTERN:
                begin
                    result_bus.ready <= ready_pattern[0];
                    ready_pattern    <= {ready_pattern[0], ready_pattern[15:1]};
                end
                default:
                begin
                    result_bus.ready <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        alu_result_t exp_res;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result transaction with none expected: value %0d, status %0d",
                         $time, result_bus.dest_value, result_bus.status);
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                status_count[exp_res.status]++;
                if (result_bus.dest_value !== exp_res.dest_value)
                begin
                    $display("%0t: dest_value of result %0d: expected %0d, actual %0d",
                             $time, result_count, exp_res.dest_value, result_bus.dest_value);
                    error_count++;
                end
                if (result_bus.status !== exp_res.status)
                begin
                    $display("%0t: status of result %0d: expected %0d, actual %0d",
                             $time, result_count, exp_res.status, result_bus.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            watchdog_count <= 0;
        end
        else if ((instr_bus.valid && instr_bus.ready) || (result_bus.valid && result_bus.ready)
                 || (cfg_bus.valid && cfg_bus.ready))
        begin
            watchdog_count <= 0;
        end
        else if (watchdog_count >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            watchdog_count <= watchdog_count + 1;
        end
    end

    initial
    begin
        int phase_cfg[NUM_PHASES];
        int count;
        instr_bus.valid       = 1'b0;
        instr_bus.func        = FUNC_ADD;
        instr_bus.dest_index  = '0;
        instr_bus.src_a_index = '0;
        instr_bus.src_b_index = '0;
        instr_bus.immediate   = '0;
        result_bus.ready      = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.regs_in_use   = REGS_IN_USE_RESET;
        rst_n                 = 1'b0;
        regs_limit            = REGS_IN_USE_RESET;
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        foreach (status_count[i]) status_count[i] = 0;
        error_count     = 0;
        result_count    = 0;
        cfg_write_count = 0;
        sent_total      = 0;
        drain_hold      = 1'b0;
        instr_fire      = 1'b0;
        burst_left      = 6;
        gap_left        = 0;
        sender_mode     = SEND_SHORT_GAPS;
        receiver_mode   = RECV_PATTERN;
        ready_pattern   = 16'hB5A3;
        phase_cfg = '{0, 1, 63, 32, 7, 33, 31, 2, 48, -1, -1, 32};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register count left at its reset value for the directed instructions.
        pending_instrs.push_back(make_instr(FUNC_LDI, 1, 0, 0, 32'sh7FFF_FFFF));
        pending_instrs.push_back(make_instr(FUNC_LDI, 2, 0, 0, 32'sh8000_0000));
        pending_instrs.push_back(make_instr(FUNC_LDI, 3, 0, 0, -32'sd1));
        pending_instrs.push_back(make_instr(FUNC_LDI, 4, 0, 0, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_LDI, 13, 0, 0, -32'sd7));
        pending_instrs.push_back(make_instr(FUNC_LDI, 14, 0, 0, 32'sd2));
        pending_instrs.push_back(make_instr(FUNC_ADD, 5, 1, 1, 32'sh1234_5678));
        pending_instrs.push_back(make_instr(FUNC_SUB, 6, 2, 1, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_MUL, 7, 2, 3, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_MUL, 8, 1, 1, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_DIV, 9, 2, 3, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_MOD, 10, 2, 3, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_DIV, 11, 1, 4, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_MOD, 12, 1, 4, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_DIV, 15, 13, 14, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_MOD, 16, 13, 14, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_DIV, 17, 1, 13, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_MOD, 18, 1, 13, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_UNKNOWN_LO, 12, 1, 2, -32'sd1));
        pending_instrs.push_back(make_instr(FUNC_UNKNOWN_HI, 31, 31, 31, -32'sd1));
        pending_instrs.push_back(make_instr(FUNC_LDI, 31, 31, 31, 32'sh5555_5555));
        pending_instrs.push_back(make_instr(FUNC_ADD, 0, 31, 31, 32'sd0));
        pending_instrs.push_back(make_instr(FUNC_SUB, 31, 0, 3, 32'sd0));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_regs_in_use(count_t'((phase_cfg[p] < 0) ? $urandom_range(1, 63)
                                                          : phase_cfg[p]));
            sender_mode   = sender_mode_e'(p % 3);
            receiver_mode = receiver_mode_e'((p + p / 3) % 3);
            ready_pattern = 16'($urandom) | 16'h0001;
            count = (regs_limit == 0) ? 40 : ITEMS_PER_PHASE;
            repeat (count) pending_instrs.push_back(random_instr());
        end

        wait_idle();
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            error_count++;
        end
        $display("Ran %0d instructions under %0d register-count writes, min/max included.",
                 sent_total, cfg_write_count);
        $display("Results: %0d ok, %0d destination not in use, %0d unknown, %0d divide by zero.",
                 status_count[ST_OK], status_count[ST_NOT_IN_USE], status_count[ST_UNKNOWN],
                 status_count[ST_DIV_ZERO]);
        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
src/tre_pkg.sv
src/tre_if.sv
src/tre_ram.sv
src/three_register_alu_execute_unit.sv
src/tre_checker.sv
tb/tb_three_register_alu_execute_unit.sv
